[design/cdeu_pkg.sv]
// Shared types and constants for the clock/date edit unit.
// No dependencies; used by cdeu_state, cdeu_fmt and clock_date_edit_unit_core.
package cdeu_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_NEXT   = 2'd1,
        OP_CHANGE = 2'd2,
        OP_LEAVE  = 2'd3
    } t_op;

    localparam logic [2:0] FIELD_HOUR   = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_SECOND = 3'd2;
    localparam logic [2:0] FIELD_DATE   = 3'd3;
    localparam logic [2:0] FIELD_MONTH  = 3'd4;
    localparam logic [2:0] FIELD_YEAR   = 3'd5;
    localparam logic [2:0] FIELD_NONE   = 3'd6;

    localparam logic [2:0] GRP_NONE   = 3'd0;
    localparam logic [2:0] GRP_HOUR   = 3'd1;
    localparam logic [2:0] GRP_MINUTE = 3'd2;
    localparam logic [2:0] GRP_SECOND = 3'd3;
    localparam logic [2:0] GRP_DATE   = 3'd4;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [4:0] step_amount;
        logic [7:0]        sec_in;
        logic [7:0]        minute_in;
        logic [7:0]        hour_in;
        logic [7:0]        date_in;
        logic [7:0]        month_in;
        logic [7:0]        year_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0] edit_field;
        logic [2:0] write_group;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
    } t_bin_result;

endpackage

[design/cdeu_state.sv]
// Input register, time/date state registers and per-transaction update logic.
// Depends on cdeu_pkg. Feeds binary results to cdeu_fmt.
module cdeu_state import cdeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_mid_valid,
    input  logic        i_mid_stall,
    output t_bin_result o_mid
);

    // highest month value a BCD load can produce (0x1F masked -> 25)
    localparam logic [7:0] MONTH_REACH = 8'd25;

    logic        r_in_vld;
    t_in_item    r_in;
    logic        r_mid_vld;
    t_bin_result r_mid;

    logic [7:0] r_hour, r_minute, r_second, r_day, r_month, r_year;
    logic [2:0] r_edit_sel;

    logic [7:0] n_hour, n_minute, n_second, n_day, n_month, n_year;
    logic [2:0] n_edit_sel;
    logic [2:0] n_group;

    logic w_mid_ready;
    logic w_in_ready;
    logic w_fire;

    logic [7:0]        w_cur;
    logic [7:0]        w_sum;
    logic signed [7:0] w_v;
    logic signed [7:0] w_lo;
    logic signed [7:0] w_mx;
    logic [7:0]        w_mr;
    logic signed [7:0] w_mdays;

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
    endfunction

    assign w_mid_ready = !r_mid_vld || !i_mid_stall;
    assign w_fire      = r_in_vld && w_mid_ready;
    assign w_in_ready  = !r_in_vld || w_mid_ready;
    assign o_in_stall  = !w_in_ready;
    assign o_mid_valid = r_mid_vld;
    assign o_mid       = r_mid;

    always_comb begin
        w_mr = (r_month > 8'd7) ? r_month + 8'd1 : r_month;
        if (r_month == 8'd2) begin
            w_mdays = (r_year[1:0] != 2'd0) ? 8'sd28 : 8'sd29;
        end else begin
            w_mdays = signed'(w_mr | 8'd30);
        end
    end

    always_comb begin
        n_hour     = r_hour;
        n_minute   = r_minute;
        n_second   = r_second;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        n_edit_sel = r_edit_sel;
        n_group    = GRP_NONE;
        w_cur      = 8'd0;
        w_lo       = 8'sd0;
        w_mx       = 8'sd0;

        case (r_edit_sel)
            FIELD_HOUR: begin
                w_cur = r_hour;   w_mx = 8'sd23;
            end
            FIELD_MINUTE: begin
                w_cur = r_minute; w_mx = 8'sd59;
            end
            FIELD_SECOND: begin
                w_cur = r_second; w_mx = 8'sd0;
            end
            FIELD_DATE: begin
                w_cur = r_day;    w_mx = w_mdays; w_lo = 8'sd1;
            end
            FIELD_MONTH: begin
                w_cur = r_month;  w_mx = 8'sd12;  w_lo = 8'sd1;
            end
            FIELD_YEAR: begin
                w_cur = r_year;   w_mx = 8'sd99;  w_lo = 8'sd1;
            end
            default: begin
                w_cur = 8'd0;
            end
        endcase

        w_sum = w_cur + {{3{r_in.step_amount[4]}}, r_in.step_amount};
        w_v   = signed'(w_sum);
        if (w_v > w_mx) begin
            w_v = w_lo;
        end
        if (w_v < w_lo) begin
            w_v = w_mx;
        end

        unique case (t_op'(r_in.opcode))
            OP_LOAD: begin
                n_second = bcd_to_bin(r_in.sec_in & 8'h7F);
                n_minute = bcd_to_bin(r_in.minute_in & 8'h7F);
                n_hour   = bcd_to_bin(r_in.hour_in & 8'h3F);
                n_day    = bcd_to_bin(r_in.date_in & 8'h3F);
                n_month  = bcd_to_bin(r_in.month_in & 8'h1F);
                n_year   = bcd_to_bin(r_in.year_in);
            end
            OP_NEXT: begin
                n_edit_sel = (r_edit_sel >= FIELD_YEAR) ? FIELD_HOUR : r_edit_sel + 3'd1;
            end
            OP_CHANGE: begin
                case (r_edit_sel)
                    FIELD_HOUR: begin
                        n_hour = w_v;   n_group = GRP_HOUR;
                    end
                    FIELD_MINUTE: begin
                        n_minute = w_v; n_group = GRP_MINUTE;
                    end
                    FIELD_SECOND: begin
                        n_second = w_v; n_group = GRP_SECOND;
                    end
                    FIELD_DATE: begin
                        n_day = w_v;    n_group = GRP_DATE;
                    end
                    FIELD_MONTH: begin
                        n_month = w_v;  n_group = GRP_DATE;
                    end
                    FIELD_YEAR: begin
                        n_year = w_v;   n_group = GRP_DATE;
                    end
                    default: begin
                        n_group = GRP_NONE;
                    end
                endcase
            end
            OP_LEAVE: begin
                n_edit_sel = FIELD_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_mid_vld  <= 1'b0;
            r_hour     <= 8'd0;
            r_minute   <= 8'd0;
            r_second   <= 8'd0;
            r_day      <= 8'd1;
            r_month    <= 8'd1;
            r_year     <= 8'd1;
            r_edit_sel <= FIELD_NONE;
        end else begin
            if (w_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_mid_ready) begin
                r_mid_vld <= r_in_vld;
            end
            if (w_fire) begin
                r_hour     <= n_hour;
                r_minute   <= n_minute;
                r_second   <= n_second;
                r_day      <= n_day;
                r_month    <= n_month;
                r_year     <= n_year;
                r_edit_sel <= n_edit_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_ready) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_mid.edit_field  <= n_edit_sel;
            r_mid.write_group <= n_group;
            r_mid.hour        <= n_hour;
            r_mid.minute      <= n_minute;
            r_mid.second      <= n_second;
            r_mid.day         <= n_day;
            r_mid.month       <= n_month;
            r_mid.year        <= n_year;
        end
    end

    a_edit_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edit_sel <= FIELD_NONE)
        else $error("edit select out of range");

    a_month_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_month <= MONTH_REACH)
        else $error("month register beyond loadable range");

    a_second_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (r_in.opcode == OP_CHANGE) && (r_edit_sel == FIELD_SECOND)
        |=> r_second == 8'd0)
        else $error("seconds edit did not clear seconds");

endmodule

[design/cdeu_fmt.sv]
// Output stage: BCD conversion, weekday calculation and the result register.
// Depends on cdeu_pkg; takes binary results from cdeu_state.
module cdeu_fmt import cdeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_bin_result i_res,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_edit_field,
    output logic [2:0]  o_write_group,
    output logic [7:0]  o_hour_out,
    output logic [7:0]  o_minute_out,
    output logic [7:0]  o_second_out,
    output logic [7:0]  o_date_out,
    output logic [2:0]  o_weekday_out,
    output logic [7:0]  o_month_out,
    output logic [7:0]  o_year_out
);

    logic       r_vld;
    logic [2:0] r_edit_field, r_write_group, r_weekday;
    logic [7:0] r_hour, r_minute, r_second, r_date, r_month, r_year;

    logic       w_ready;
    logic       w_a;
    logic [7:0] w_y;
    logic [7:0] w_m;
    logic [6:0] w_mterm;
    logic [9:0] w_sum;
    logic [4:0] w_s1;
    logic [3:0] w_s2;
    logic [2:0] w_s3;
    logic [2:0] w_wday;

    function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  rem;
        p   = {8'd0, v} * 16'd205;
        q   = {3'd0, p[15:11]};
        rem = v - (q << 3) - (q << 1);
        return {q[3:0], 4'd0} + rem;
    endfunction

    // floor(31*m/12) for m below 32
    function automatic logic [6:0] month_term(input logic [4:0] m);
        logic [6:0] t;
        case (m)
            5'd0:  t = 7'd0;   5'd1:  t = 7'd2;   5'd2:  t = 7'd5;   5'd3:  t = 7'd7;
            5'd4:  t = 7'd10;  5'd5:  t = 7'd12;  5'd6:  t = 7'd15;  5'd7:  t = 7'd18;
            5'd8:  t = 7'd20;  5'd9:  t = 7'd23;  5'd10: t = 7'd25;  5'd11: t = 7'd28;
            5'd12: t = 7'd31;  5'd13: t = 7'd33;  5'd14: t = 7'd36;  5'd15: t = 7'd38;
            5'd16: t = 7'd41;  5'd17: t = 7'd43;  5'd18: t = 7'd46;  5'd19: t = 7'd49;
            5'd20: t = 7'd51;  5'd21: t = 7'd54;  5'd22: t = 7'd56;  5'd23: t = 7'd59;
            5'd24: t = 7'd62;  5'd25: t = 7'd64;  5'd26: t = 7'd67;  5'd27: t = 7'd69;
            5'd28: t = 7'd72;  5'd29: t = 7'd74;  5'd30: t = 7'd77;  default: t = 7'd80;
        endcase
        return t;
    endfunction

    always_comb begin
        w_a     = (i_res.month <= 8'd2);
        w_y     = w_a ? i_res.year + 8'd11 : i_res.year + 8'd12;
        w_m     = w_a ? i_res.month + 8'd10 : i_res.month - 8'd2;
        w_mterm = month_term(w_m[4:0]);
        w_sum   = {2'd0, i_res.day} + {2'd0, w_y} + {4'd0, w_y[7:2]} + {3'd0, w_mterm};
        // mod 7 by folding octal digits (8 == 1 mod 7); 7 stands for zero
        w_s1    = {2'd0, w_sum[2:0]} + {2'd0, w_sum[5:3]} + {2'd0, w_sum[8:6]}
                + {4'd0, w_sum[9]};
        w_s2    = {1'b0, w_s1[2:0]} + {2'd0, w_s1[4:3]};
        w_s3    = w_s2[2:0] + {2'd0, w_s2[3]};
        w_wday  = (w_s3 == 3'd0) ? 3'd7 : w_s3;
    end

    assign w_ready = !r_vld || !i_out_stall;
    assign o_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_ready) begin
            r_edit_field  <= i_res.edit_field;
            r_write_group <= i_res.write_group;
            r_hour        <= bin_to_bcd(i_res.hour);
            r_minute      <= bin_to_bcd(i_res.minute);
            r_second      <= bin_to_bcd(i_res.second);
            r_date        <= bin_to_bcd(i_res.day);
            r_month       <= bin_to_bcd(i_res.month);
            r_year        <= bin_to_bcd(i_res.year);
            r_weekday     <= w_wday;
        end
    end

    assign o_out_valid   = r_vld;
    assign o_edit_field  = r_edit_field;
    assign o_write_group = r_write_group;
    assign o_hour_out    = r_hour;
    assign o_minute_out  = r_minute;
    assign o_second_out  = r_second;
    assign o_date_out    = r_date;
    assign o_weekday_out = r_weekday;
    assign o_month_out   = r_month;
    assign o_year_out    = r_year;

    a_weekday_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_weekday_out != 3'd0)
        else $error("weekday zero");

    a_group_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_write_group <= GRP_DATE)
        else $error("write group out of range");

    a_group_needs_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_write_group != GRP_NONE) |-> o_edit_field < FIELD_NONE)
        else $error("write group set outside edit mode");

endmodule

[design/clock_date_edit_unit_core.sv]
// A transaction passes through the input, state result and output registers.
// Throughput: one transaction per cycle while nothing stalls; the state registers
// update on firing; output stall goes combinationally back through all stages.
// Reset (synchronous, active low) empties the pipeline and sets time 00:00:00,
// date 1/1/01 and edit mode off.
module clock_date_edit_unit_core import cdeu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic signed [4:0] i_step_amount,
    input  logic [7:0]  i_sec_in,
    input  logic [7:0]  i_minute_in,
    input  logic [7:0]  i_hour_in,
    input  logic [7:0]  i_date_in,
    input  logic [7:0]  i_month_in,
    input  logic [7:0]  i_year_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_edit_field,
    output logic [2:0]  o_write_group,
    output logic [7:0]  o_hour_out,
    output logic [7:0]  o_minute_out,
    output logic [7:0]  o_second_out,
    output logic [7:0]  o_date_out,
    output logic [2:0]  o_weekday_out,
    output logic [7:0]  o_month_out,
    output logic [7:0]  o_year_out
);

    t_in_item    w_in;
    t_bin_result w_mid;
    logic        w_mid_valid;
    logic        w_mid_stall;

    always_comb begin
        w_in.opcode      = i_opcode;
        w_in.step_amount = i_step_amount;
        w_in.sec_in      = i_sec_in;
        w_in.minute_in   = i_minute_in;
        w_in.hour_in     = i_hour_in;
        w_in.date_in     = i_date_in;
        w_in.month_in    = i_month_in;
        w_in.year_in     = i_year_in;
    end

    cdeu_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (w_in),
        .o_mid_valid (w_mid_valid),
        .i_mid_stall (w_mid_stall),
        .o_mid       (w_mid)
    );

    cdeu_fmt u_fmt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_mid_valid),
        .o_stall       (w_mid_stall),
        .i_res         (w_mid),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_edit_field  (o_edit_field),
        .o_write_group (o_write_group),
        .o_hour_out    (o_hour_out),
        .o_minute_out  (o_minute_out),
        .o_second_out  (o_second_out),
        .o_date_out    (o_date_out),
        .o_weekday_out (o_weekday_out),
        .o_month_out   (o_month_out),
        .o_year_out    (o_year_out)
    );

endmodule
